[hdl/ptc_pkg.sv]
// Shared types and constants for the PPS time counter.
`default_nettype none

package ptc_pkg;

    // Request kinds carried by req_type
    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_PPS  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // Frame state codes as shown on frame_state
    localparam logic [1:0] FS_IDLE    = 2'd0;
    localparam logic [1:0] FS_MARK1   = 2'd1;
    localparam logic [1:0] FS_COLLECT = 2'd2;
    localparam logic [1:0] FS_TIMEOK  = 2'd3;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_NS_PER_CYCLE  = 2'd0;
    localparam logic [1:0] REG_FIRST_MARKER  = 2'd1;
    localparam logic [1:0] REG_SECOND_MARKER = 2'd2;

    localparam int unsigned APB_ADDR_W = 4;

    // Register reset values (ns per cycle for 72000065 Hz, Q8.24)
    localparam logic [31:0] NS_PER_CYCLE_RST  = 32'd233016678;
    localparam logic [7:0]  FIRST_MARKER_RST  = 8'h16;
    localparam logic [7:0]  SECOND_MARKER_RST = 8'h03;

    // Time-of-day status travelling with one item down the pipe
    typedef struct packed {
        logic [31:0] seconds;
        logic        time_set;
        logic [1:0]  frame_state;
    } ptc_status_t;

endpackage : ptc_pkg

`default_nettype wire

[hdl/ptc_if.sv]
// Valid/ready channel interfaces for request and result items.
`default_nettype none

interface ptc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface : ptc_in_if

interface ptc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] seconds_out;
    logic [31:0] nanoseconds_out;
    logic        time_set;
    logic [1:0]  frame_state;

    modport source (output valid, output seconds_out, output nanoseconds_out,
                    output time_set, output frame_state, input ready);
    modport sink   (input valid, input seconds_out, input nanoseconds_out,
                    input time_set, input frame_state, output ready);
endinterface : ptc_out_if

`default_nettype wire

[hdl/ptc_frame_parser.sv]
// Frame parser and seconds/cycle counters; registers a status snapshot per item.
`default_nettype none

module ptc_frame_parser
    import ptc_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               req_type,
    input  wire logic [7:0]               rx_byte,
    input  wire logic [7:0]               first_marker,
    input  wire logic [7:0]               second_marker,
    input  wire logic                     snap_take,
    output logic                          snap_valid,
    output ptc_status_t                   snap,
    output logic [COUNTER_WIDTH-1:0]      snap_cycles
);

    typedef enum logic [3:0] {
        PS_IDLE    = 4'b0001,
        PS_MARK1   = 4'b0010,
        PS_COLLECT = 4'b0100,
        PS_TIMEOK  = 4'b1000
    } parser_state_t;

    parser_state_t              state_reg,  state_next;
    logic [1:0]                 count_reg,  count_next;
    logic [3:0][7:0]            word_reg,   word_next;
    logic [31:0]                sec_reg,    sec_next;
    logic [COUNTER_WIDTH-1:0]   cyc_reg,    cyc_next;
    logic                       en_reg,     en_next;
    logic                       valid_reg;
    ptc_status_t                snap_reg,   snap_next;
    logic [COUNTER_WIDTH-1:0]   scyc_reg;
    logic                       advance;
    logic                       accept;
    logic [1:0]                 fs_code;

    // Stage moves on when empty or when the scaler takes it
    assign advance  = !valid_reg || snap_take;
    assign in_ready = advance;
    assign accept   = in_valid && advance;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        word_next  = word_reg;
        sec_next   = sec_reg;
        cyc_next   = cyc_reg;
        en_next    = en_reg;
        case (req_type)
            REQ_BYTE:
            begin
                case (state_reg)
                    PS_IDLE:
                    begin
                        if (rx_byte == first_marker)
                            state_next = PS_MARK1;
                    end
                    PS_MARK1:
                    begin
                        if (rx_byte == second_marker)
                        begin
                            state_next = PS_COLLECT;
                            count_next = 2'd0;
                        end
                        else
                            state_next = PS_IDLE;
                    end
                    PS_COLLECT:
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            if (count_reg == 2'(i))
                                word_next[i] = rx_byte;
                        end
                        count_next = count_reg + 2'd1;
                        if (count_reg == 2'd3)
                        begin
                            sec_next   = word_next;
                            state_next = PS_TIMEOK;
                            if (!en_reg)
                            begin
                                en_next  = 1'b1;
                                cyc_next = '0;
                            end
                        end
                    end
                    default:
                    begin
                        if (rx_byte == first_marker)
                            state_next = PS_MARK1;
                    end
                endcase
            end
            REQ_PPS:
            begin
                if (en_reg)
                begin
                    sec_next = sec_reg + 32'd1;
                    cyc_next = '0;
                end
            end
            REQ_TICK:
            begin
                if (en_reg)
                    cyc_next = cyc_reg + COUNTER_WIDTH'(1);
            end
            default:
            begin
                // unused request kind: no change
            end
        endcase
    end

    always_comb
    begin
        case (state_next)
            PS_IDLE:    fs_code = FS_IDLE;
            PS_MARK1:   fs_code = FS_MARK1;
            PS_COLLECT: fs_code = FS_COLLECT;
            PS_TIMEOK:  fs_code = FS_TIMEOK;
            default:    fs_code = FS_IDLE;
        endcase
        snap_next.seconds     = sec_next;
        snap_next.time_set    = en_next;
        snap_next.frame_state = fs_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_IDLE;
            count_reg <= 2'd0;
            sec_reg   <= '0;
            cyc_reg   <= '0;
            en_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                count_reg <= count_next;
                sec_reg   <= sec_next;
                cyc_reg   <= cyc_next;
                en_reg    <= en_next;
            end
            if (advance)
                valid_reg <= in_valid;
        end
    end

    // Payload: assembly word and snapshot need no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
            snap_reg <= snap_next;
            scyc_reg <= cyc_next;
        end
    end

    assign snap_valid  = valid_reg;
    assign snap        = snap_reg;
    assign snap_cycles = scyc_reg;

endmodule : ptc_frame_parser

`default_nettype wire

[hdl/ptc_ns_scaler.sv]
// Cycle-to-nanosecond scaling (multiply stage, saturate into output register).
`default_nettype none

module ptc_ns_scaler
    import ptc_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     snap_valid,
    output logic                          snap_take,
    input  wire ptc_status_t              snap,
    input  wire logic [COUNTER_WIDTH-1:0] snap_cycles,
    input  wire logic [31:0]              ns_per_cycle,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output ptc_status_t                   out_status,
    output logic [31:0]                   out_ns
);

    logic [63:0]  cyc_ext;
    logic         mul_valid_reg;
    logic [63:0]  hi_reg, lo_reg;
    ptc_status_t  mul_status_reg;
    logic         res_valid_reg;
    ptc_status_t  res_status_reg;
    logic [31:0]  res_ns_reg, res_ns_next;
    logic [40:0]  sum;
    logic         sat;
    logic         mul_adv, res_adv;

    assign res_adv   = !res_valid_reg || out_ready;
    assign mul_adv   = !mul_valid_reg || res_adv;
    assign snap_take = mul_adv;

    assign cyc_ext = 64'(snap_cycles);

    // (hi * 2^32 + lo) >> 24, saturated to 32 bits
    always_comb
    begin
        sum         = {9'd0, hi_reg[23:0], 8'd0} + {1'b0, lo_reg[63:24]};
        sat         = (|hi_reg[63:24]) || (|sum[40:32]);
        res_ns_next = sat ? 32'hFFFF_FFFF : sum[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (mul_adv)
                mul_valid_reg <= snap_valid;
            if (res_adv)
                res_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_adv && snap_valid)
        begin
            hi_reg         <= 64'(cyc_ext[63:32]) * 64'(ns_per_cycle);
            lo_reg         <= 64'(cyc_ext[31:0]) * 64'(ns_per_cycle);
            mul_status_reg <= snap;
        end
        if (res_adv && mul_valid_reg)
        begin
            res_ns_reg     <= res_ns_next;
            res_status_reg <= mul_status_reg;
        end
    end

    assign out_valid  = res_valid_reg;
    assign out_status = res_status_reg;
    assign out_ns     = res_ns_reg;

endmodule : ptc_ns_scaler

`default_nettype wire

[hdl/pps_time_counter_with_serial_set.sv]
// Top level: PPS-disciplined time-of-day counter with serial time set.
//
//  Channel   Direction  Handshake       Payload
//  in_ch     sink       valid / ready   req_type[1:0], rx_byte[7:0]
//  out_ch    source     valid / ready   seconds_out, nanoseconds_out, time_set, frame_state
//  APB       slave      psel / penable  paddr[3:0], pwdata[31:0], prdata[31:0]
//
// One item accepted per cycle unless out_ch stalls; each result is offered from stage 3.
// Counter state is updated in the cycle the item is taken, then the cycle
// count is scaled by two 32x32 multipliers and saturated in the next two stages.
// Reset (rst_n low) clears parser, counters and all pipe valid flags.
// A stall on out_ch holds the output register and back-pressures stage by
// stage; bubbles are squeezed out, so in_ch stays ready while the pipe has room.
//
// Registers: 0x0 ns_per_cycle (Q8.24), 0x4 first_marker, 0x8 second_marker.
`default_nettype none

module pps_time_counter_with_serial_set
    import ptc_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ptc_in_if.sink                     in_ch,
    ptc_out_if.source                  out_ch,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [31:0]              ns_per_cycle_reg;
    logic [7:0]               first_marker_reg;
    logic [7:0]               second_marker_reg;
    logic                     cfg_write;
    logic [1:0]               cfg_index;

    logic                     snap_valid;
    logic                     snap_take;
    ptc_status_t              snap;
    logic [COUNTER_WIDTH-1:0] snap_cycles;
    ptc_status_t              out_status;

    // ---- configuration port: no wait states ----
    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_per_cycle_reg  <= NS_PER_CYCLE_RST;
            first_marker_reg  <= FIRST_MARKER_RST;
            second_marker_reg <= SECOND_MARKER_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NS_PER_CYCLE:  ns_per_cycle_reg  <= pwdata;
                REG_FIRST_MARKER:  first_marker_reg  <= pwdata[7:0];
                REG_SECOND_MARKER: second_marker_reg <= pwdata[7:0];
                default:
                begin
                    // unmapped address: write dropped
                end
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_NS_PER_CYCLE:  prdata = ns_per_cycle_reg;
            REG_FIRST_MARKER:  prdata = {24'd0, first_marker_reg};
            REG_SECOND_MARKER: prdata = {24'd0, second_marker_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // ---- stage 1: frame parser and counters ----
    ptc_frame_parser #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_ch.valid),
        .in_ready      (in_ch.ready),
        .req_type      (in_ch.req_type),
        .rx_byte       (in_ch.rx_byte),
        .first_marker  (first_marker_reg),
        .second_marker (second_marker_reg),
        .snap_take     (snap_take),
        .snap_valid    (snap_valid),
        .snap          (snap),
        .snap_cycles   (snap_cycles)
    );

    // ---- stages 2-3: ns scaling and output register ----
    ptc_ns_scaler #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_scaler (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap_valid   (snap_valid),
        .snap_take    (snap_take),
        .snap         (snap),
        .snap_cycles  (snap_cycles),
        .ns_per_cycle (ns_per_cycle_reg),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_status   (out_status),
        .out_ns       (out_ch.nanoseconds_out)
    );

    assign out_ch.seconds_out = out_status.seconds;
    assign out_ch.time_set    = out_status.time_set;
    assign out_ch.frame_state = out_status.frame_state;

endmodule : pps_time_counter_with_serial_set

`default_nettype wire

[hdl/ptc_checker.sv]
// Port-level assertions for the PPS time counter, bound to the top level.
`default_nettype none

module ptc_checker
    import ptc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] nanoseconds_out,
    input wire logic        time_set,
    input wire logic [1:0]  frame_state
);

    // A result waiting on a stalled sink stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Once time is set it never clears for later results
    a_time_set_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && time_set |=> time_set)
        else $error("time_set fell after being set");

    // Time-set frame state only after a full frame
    a_timeok_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_state == FS_TIMEOK) |-> time_set)
        else $error("frame state time-set without time_set");

    // No counting before the first frame
    a_ns_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !time_set |-> (nanoseconds_out == 32'd0))
        else $error("nanoseconds non-zero before time set");

endmodule : ptc_checker

bind pps_time_counter_with_serial_set ptc_checker u_ptc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .nanoseconds_out (out_ch.nanoseconds_out),
    .time_set        (out_ch.time_set),
    .frame_state     (out_ch.frame_state)
);

`default_nettype wire
